FILE: rtl/core/bgd_pkg.sv
// Package for the button gesture detector: transaction structs, event codes,
// register indexes and shared constants. Depends on nothing.
package bgd_pkg;

    // Widths fixed by the item fields and registers
    localparam int CFG_WIDTH          = 32;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int NOW_WIDTH          = 32;
    localparam int TIME_WIDTH_DEFAULT = 32;

    // Event queue between the gesture logic and the result channel
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_CLICK = 2'd2;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET     = 32'd50;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET   = 32'd1000;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_RESET = 32'd300;

    typedef enum logic [2:0] {
        EV_PRESSED       = 3'd0,
        EV_RELEASED      = 3'd1,
        EV_CLICKED       = 3'd2,
        EV_DOUBLE        = 3'd3,
        EV_LONG          = 3'd4,
        EV_LONG_RELEASED = 3'd5
    } ev_code_t;

    typedef struct packed {
        logic                 raw_pressed;
        logic [NOW_WIDTH-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        ev_code_t event_code;
        logic     last_event;
    } out_item_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ms;
        logic [CFG_WIDTH-1:0] long_press_ms;
        logic [CFG_WIDTH-1:0] double_click_window_ms;
    } cfg_t;

    // Events produced by one sample, in delivery order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } ev_pair_t;

endpackage

FILE: rtl/core/bgd_gesture_core.sv
// Gesture logic: debounce, press timing and click pairing state, with the
// single-pass next-state and event logic. Depends on bgd_pkg.
module bgd_gesture_core #(
    parameter int TIME_WIDTH = bgd_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  bgd_pkg::in_item_t sample,
    input  bgd_pkg::cfg_t     cfg,
    output bgd_pkg::ev_pair_t events
);

    // Compare width covers both elapsed times and 32-bit registers
    localparam int CMP_WIDTH = (TIME_WIDTH > bgd_pkg::CFG_WIDTH) ? TIME_WIDTH
                                                                  : bgd_pkg::CFG_WIDTH;

    logic                  last_raw_reg, last_raw_next;
    logic                  stable_reg, stable_next;
    logic [TIME_WIDTH-1:0] change_time_reg, change_time_next;
    logic [TIME_WIDTH-1:0] press_start_reg, press_start_next;
    logic [TIME_WIDTH-1:0] pend_time_reg, pend_time_next;
    logic                  long_seen_reg, long_seen_next;
    logic                  awaiting_reg, awaiting_next;

    logic                  level;
    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] since_press;
    logic [TIME_WIDTH-1:0] since_pend_old;
    logic [TIME_WIDTH-1:0] since_pend_new;
    logic                  stable_change;

    bgd_pkg::ev_code_t     code0, code1;
    logic [1:0]            count;

    assign level = sample.raw_pressed;
    assign now   = TIME_WIDTH'(sample.now_ms);

    // Next state and events for the sample in the input register
    always_comb
    begin
        last_raw_next    = last_raw_reg;
        stable_next      = stable_reg;
        change_time_next = change_time_reg;
        press_start_next = press_start_reg;
        pend_time_next   = pend_time_reg;
        long_seen_next   = long_seen_reg;
        awaiting_next    = awaiting_reg;
        code0            = bgd_pkg::EV_PRESSED;
        code1            = bgd_pkg::EV_PRESSED;
        count            = 2'd0;

        // Restart the debounce timer on a raw level change
        if (level != last_raw_reg)
        begin
            change_time_next = now;
            last_raw_next    = level;
        end
        since_change   = now - change_time_next;
        since_pend_old = now - pend_time_reg;

        stable_change = (CMP_WIDTH'(since_change) >= CMP_WIDTH'(cfg.debounce_ms))
                        && (level != stable_reg);

        if (stable_change)
        begin
            stable_next = level;
            if (level)
            begin
                press_start_next = now;
                long_seen_next   = 1'b0;
                code0            = bgd_pkg::EV_PRESSED;
                count            = 2'd1;
            end
            else
            begin
                code0 = bgd_pkg::EV_RELEASED;
                count = 2'd1;
                if (long_seen_reg)
                begin
                    code1          = bgd_pkg::EV_LONG_RELEASED;
                    count          = 2'd2;
                    long_seen_next = 1'b0;
                    awaiting_next  = 1'b0;
                end
                else if (awaiting_reg && (CMP_WIDTH'(since_pend_old)
                                          <= CMP_WIDTH'(cfg.double_click_window_ms)))
                begin
                    code1         = bgd_pkg::EV_DOUBLE;
                    count         = 2'd2;
                    awaiting_next = 1'b0;
                end
                else
                begin
                    awaiting_next  = 1'b1;
                    pend_time_next = now;
                end
            end
        end

        // Long press once the stable press has lasted long enough
        since_press = now - press_start_next;
        if (stable_next && !long_seen_next
            && (CMP_WIDTH'(since_press) >= CMP_WIDTH'(cfg.long_press_ms)))
        begin
            long_seen_next = 1'b1;
            if (count == 2'd0)
            begin
                code0 = bgd_pkg::EV_LONG;
                count = 2'd1;
            end
            else if (count == 2'd1)
            begin
                code1 = bgd_pkg::EV_LONG;
                count = 2'd2;
            end
        end

        // Single click once the window has passed while released
        since_pend_new = now - pend_time_next;
        if (awaiting_next && !stable_next
            && (CMP_WIDTH'(since_pend_new) > CMP_WIDTH'(cfg.double_click_window_ms)))
        begin
            awaiting_next = 1'b0;
            if (count == 2'd0)
            begin
                code0 = bgd_pkg::EV_CLICKED;
                count = 2'd1;
            end
            else if (count == 2'd1)
            begin
                code1 = bgd_pkg::EV_CLICKED;
                count = 2'd2;
            end
        end

        events.count             = count;
        events.first.event_code  = code0;
        events.first.last_event  = (count == 2'd1);
        events.second.event_code = code1;
        events.second.last_event = 1'b1;
    end

    // Commit state when the sample is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
            press_start_reg <= '0;
            pend_time_reg   <= '0;
            long_seen_reg   <= 1'b0;
            awaiting_reg    <= 1'b0;
        end
        else if (fire)
        begin
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
            press_start_reg <= press_start_next;
            pend_time_reg   <= pend_time_next;
            long_seen_reg   <= long_seen_next;
            awaiting_reg    <= awaiting_next;
        end
    end

endmodule

FILE: rtl/core/bgd_event_fifo.sv
// Event queue: takes up to two events per push and delivers one result
// transaction at a time. Depends on bgd_pkg.
module bgd_event_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bgd_pkg::ev_pair_t  events,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output bgd_pkg::out_item_t out_data
);

    localparam int PW = bgd_pkg::FIFO_PTR_WIDTH;
    localparam int CW = bgd_pkg::FIFO_CNT_WIDTH;

    bgd_pkg::out_item_t mem_reg [bgd_pkg::FIFO_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_second;
    logic [CW-1:0] push_count;
    logic          pop;

    assign room          = (count_reg <= CW'(bgd_pkg::FIFO_DEPTH - 2));
    assign out_valid     = (count_reg != '0);
    assign out_data      = mem_reg[rd_ptr_reg];
    assign pop           = out_valid && !out_stall;
    assign wr_ptr_second = wr_ptr_reg + PW'(1);
    assign push_count    = push ? CW'(events.count) : '0;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + push_count - (pop ? CW'(1) : CW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the events of one sample in order
    always_ff @(posedge clk)
    begin
        if (push && (events.count != 2'd0))
        begin
            mem_reg[wr_ptr_reg] <= events.first;
        end
        if (push && (events.count == 2'd2))
        begin
            mem_reg[wr_ptr_second] <= events.second;
        end
    end

endmodule

FILE: rtl/core/button_gesture_detector.sv
// Button gesture detector top level: input register, configuration
// registers, gesture core and event queue. Depends on bgd_pkg,
// bgd_gesture_core and bgd_event_fifo.
//
// Each input transaction is one poll sample (raw level and millisecond
// timestamp). A sample is taken into the input register, processed in one
// pass once the queue has room, and its zero, one or two events are
// written to a four-entry event queue; each event leaves as its own result
// transaction, the final one of a sample marked by last_event. A new sample
// is accepted every cycle while the queue has room for two more events, so
// the input side runs at one sample per cycle and the result side, while
// out_stall is low, at one event per cycle. The first event of a sample is
// offered once the sample has passed the input register and been written
// into the queue. Registers are written through cfg_wr_en, cfg_index and
// cfg_data; an index beyond the third register is ignored.
module button_gesture_detector #(
    parameter int TIME_WIDTH = bgd_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bgd_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bgd_pkg::out_item_t                  out_data,
    input  logic                                cfg_wr_en,
    input  logic [bgd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bgd_pkg::CFG_WIDTH-1:0]       cfg_data
);

    bgd_pkg::cfg_t     cfg_reg;
    bgd_pkg::in_item_t sample_reg;
    logic              sample_vld_reg;
    logic              room;
    logic              fire;
    logic              accept;
    bgd_pkg::ev_pair_t events;

    assign fire     = sample_vld_reg && room;
    assign in_stall = sample_vld_reg && !room;
    assign accept   = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms            <= bgd_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms          <= bgd_pkg::LONG_PRESS_RESET;
            cfg_reg.double_click_window_ms <= bgd_pkg::DOUBLE_CLICK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bgd_pkg::REG_DEBOUNCE:     cfg_reg.debounce_ms            <= cfg_data;
                bgd_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ms          <= cfg_data;
                bgd_pkg::REG_DOUBLE_CLICK: cfg_reg.double_click_window_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the accepted sample until the core processes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            sample_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            sample_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_data;
        end
    end

    bgd_gesture_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .sample (sample_reg),
        .cfg    (cfg_reg),
        .events (events)
    );

    bgd_event_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .events    (events),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
